FILE: hdl/ippl_pkg.sv
`default_nettype none
package ippl_pkg;
    localparam int DEF_MAX_PAGES = 64;

    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [1:0] ACT_LOOKUP     = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    localparam logic [31:0] CELL_INDEX_NONE = 32'hFFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item, clear scan results
        logic scan_start; // clear scan index
        logic scan_step;  // read/compare one entry
        logic reg_write;  // write new entry at free slot
        logic unreg;      // invalidate matched entry
        logic fetch;      // read best entry
        logic hit_eval;   // check containment
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic finish;     // form result
    } ippl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       scan_last;
        logic       dup;
        logic       full;
        logic       match;
        logic       best_any;
        logic       hit;
        logic       cell_nz;
        logic       div_last;
    } ippl_stat_t;
endpackage
`default_nettype wire

FILE: hdl/ippl_datapath.sv
`default_nettype none
module ippl_datapath
    import ippl_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ippl_cmd_t   cmd,
    output ippl_stat_t       stat,
    input  wire logic [1:0]  in_action,
    input  wire logic [63:0] in_address,
    input  wire logic [31:0] in_page_bytes,
    input  wire logic [15:0] in_cell_bytes,
    input  wire logic [31:0] in_zone,
    output logic [1:0]       status,
    output logic [63:0]      cell_start,
    output logic [15:0]      hit_cell_bytes,
    output logic [31:0]      cell_index,
    output logic [31:0]      hit_zone,
    output logic             found,
    output logic             in_heap,
    output logic             at_boundary,
    output logic [6:0]       page_total,
    output logic [38:0]      mapped_bytes
);
    localparam int IW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);

    // page table memory, one packed word per entry
    typedef struct packed {
        logic [63:0] base;
        logic [31:0] bytes;
        logic [15:0] cell_sz;
        logic [31:0] zone;
    } entry_t;

    entry_t               mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] valid_reg;
    entry_t               rd_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 rd_vld_reg;

    logic [1:0]   act_reg;
    logic [63:0]  addr_reg;
    logic [31:0]  pbytes_reg;
    logic [15:0]  cbytes_reg;
    logic [31:0]  zone_reg;

    logic [IW:0]  scan_reg;
    logic         dup_reg, match_reg, best_any_reg, free_any_reg;
    logic [IW-1:0] match_idx_reg, best_idx_reg, free_idx_reg;
    logic [31:0]  match_bytes_reg;
    logic [63:0]  best_base_reg;

    logic [CW-1:0] count_reg;
    logic [38:0]   sum_reg;

    entry_t       hit_reg;
    logic         hit_flag_reg;
    logic [63:0]  off_reg;
    logic [31:0]  quo_reg;
    logic [32:0]  rem_reg;
    logic [5:0]   div_cnt_reg;

    logic [32:0]  rem_shift;
    logic [47:0]  prod;

    assign rem_shift = {rem_reg[31:0], quo_reg[31]};
    assign prod = quo_reg * hit_reg.cell_sz;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.reg_write)
        begin
            mem[free_idx_reg] <= '{addr_reg, pbytes_reg, cbytes_reg, zone_reg};
        end
        if (cmd.fetch)
        begin
            rd_reg <= mem[best_idx_reg];
        end
        else
        begin
            rd_reg <= mem[scan_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            scan_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            dup_reg      <= 1'b0;
            match_reg    <= 1'b0;
            best_any_reg <= 1'b0;
            free_any_reg <= 1'b0;
            div_cnt_reg  <= '0;
            hit_flag_reg <= 1'b0;
        end
        else
        begin
            // capture item
            if (cmd.load)
            begin
                act_reg      <= in_action;
                addr_reg     <= in_address;
                pbytes_reg   <= in_page_bytes;
                cbytes_reg   <= in_cell_bytes;
                zone_reg     <= in_zone;
                dup_reg      <= 1'b0;
                match_reg    <= 1'b0;
                best_any_reg <= 1'b0;
                free_any_reg <= 1'b0;
                hit_flag_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                scan_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            // scan: address issued, compare the entry read last cycle
            if (cmd.scan_step)
            begin
                if (scan_reg < (IW+1)'(MAX_PAGES))
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                rd_vld_reg <= (scan_reg < (IW+1)'(MAX_PAGES));
                rd_idx_reg <= scan_reg[IW-1:0];
                if (rd_vld_reg)
                begin
                    if (valid_reg[rd_idx_reg])
                    begin
                        if (rd_reg.base == addr_reg && !match_reg)
                        begin
                            match_reg       <= 1'b1;
                            dup_reg         <= 1'b1;
                            match_idx_reg   <= rd_idx_reg;
                            match_bytes_reg <= rd_reg.bytes;
                        end
                        if (rd_reg.base <= addr_reg &&
                            (!best_any_reg || rd_reg.base > best_base_reg))
                        begin
                            best_any_reg  <= 1'b1;
                            best_idx_reg  <= rd_idx_reg;
                            best_base_reg <= rd_reg.base;
                        end
                    end
                    else if (!free_any_reg)
                    begin
                        free_any_reg <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                end
            end
            if (cmd.reg_write)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + 39'(pbytes_reg);
            end
            // unregister: drop matched entry, its length was held during the scan
            if (cmd.unreg)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                sum_reg   <= sum_reg - 39'(match_bytes_reg);
            end
            if (cmd.hit_eval)
            begin
                hit_reg      <= rd_reg;
                off_reg      <= addr_reg - rd_reg.base;
                hit_flag_reg <= (addr_reg - rd_reg.base) < 64'(rd_reg.bytes);
            end
            // restoring divide, offset below 2^32 on a hit
            if (cmd.div_start)
            begin
                quo_reg     <= off_reg[31:0];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                if (rem_shift >= {17'd0, hit_reg.cell_sz})
                begin
                    rem_reg <= rem_shift - {17'd0, hit_reg.cell_sz};
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status         <= (act_reg == ACT_REGISTER) ?
                              (dup_reg ? ST_DUP :
                               !free_any_reg ? ST_FULL : ST_OK) : ST_OK;
            cell_start     <= '0;
            hit_cell_bytes <= '0;
            cell_index     <= CELL_INDEX_NONE;
            hit_zone       <= '0;
            found          <= 1'b0;
            in_heap        <= 1'b0;
            at_boundary    <= 1'b0;
            if (act_reg == ACT_LOOKUP && hit_flag_reg)
            begin
                in_heap        <= 1'b1;
                hit_cell_bytes <= hit_reg.cell_sz;
                hit_zone       <= hit_reg.zone;
                if (hit_reg.cell_sz != 16'd0)
                begin
                    cell_start  <= hit_reg.base + 64'(prod);
                    cell_index  <= quo_reg;
                    at_boundary <= (rem_reg == 33'd0);
                    found       <= (hit_reg.base + 64'(prod)) != 64'd0;
                end
            end
        end
        page_total   <= 7'(count_reg);
        mapped_bytes <= sum_reg;
    end

    always_comb
    begin
        stat.action    = act_reg;
        stat.scan_last = rd_vld_reg == 1'b0 && scan_reg == (IW+1)'(MAX_PAGES);
        stat.dup       = dup_reg;
        stat.full      = count_reg >= CW'(MAX_PAGES);
        stat.match     = match_reg;
        stat.best_any  = best_any_reg;
        stat.hit       = hit_flag_reg;
        stat.cell_nz   = hit_reg.cell_sz != 16'd0;
        stat.div_last  = div_cnt_reg == 6'd31;
    end
endmodule
`default_nettype wire

FILE: hdl/ippl_ctrl.sv
`default_nettype none
module ippl_ctrl
    import ippl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire ippl_stat_t stat,
    output ippl_cmd_t       cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_FETCH, S_EVAL, S_DIVST, S_DIV,
        S_FIN, S_OUT, S_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.scan_step = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_FIN;
                if (stat.action == ACT_REGISTER && !stat.dup && !stat.full)
                begin
                    cmd.reg_write = 1'b1;
                end
                else if (stat.action == ACT_UNREGISTER && stat.match)
                begin
                    cmd.unreg = 1'b1;
                end
                else if (stat.action == ACT_LOOKUP && stat.best_any)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.hit_eval = 1'b1;
                state_next = S_DIVST;
            end
            S_DIVST:
            begin
                cmd.div_start = 1'b1;
                state_next = (stat.hit && stat.cell_nz) ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/interior_pointer_page_lookup.sv
`default_nettype none
// Result paths: register, unregister, unused action and a lookup below every page end
// after the table scan; a lookup that misses its candidate page or hits a page with zero
// cell size adds the fetch and containment check; a hit with nonzero cell size goes on
// from there to the 32-step divider (table scan, fetch, then divider).
// Throughput: one item at a time; input is ready again the cycle after the result transfer.
// Reset: async active low clears valid bits, page count and byte sum.
module interior_pointer_page_lookup
    import ippl_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // action[1:0]
    input  wire logic [1:0]   s_tuser,
    // address[63:0], page_bytes[95:64], cell_bytes[111:96], zone_number[143:112]
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], cell_start[65:2], hit_cell_bytes[81:66],
    // cell_index[113:82], hit_zone[145:114], found[146], in_heap[147],
    // at_boundary[148], page_total[155:149], mapped_bytes[194:156],
    // zero fill to 200
    output logic [199:0]      m_tdata
);
    ippl_cmd_t  cmd;
    ippl_stat_t stat;
    logic       in_fire;

    logic [1:0]  status;
    logic [63:0] cell_start;
    logic [15:0] hit_cell_bytes;
    logic [31:0] cell_index, hit_zone;
    logic        found, in_heap, at_boundary;
    logic [6:0]  page_total;
    logic [38:0] mapped_bytes;

    assign in_fire = s_tvalid && s_tready;

    ippl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
    );

    ippl_datapath #(.MAX_PAGES(MAX_PAGES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_action(s_tuser), .in_address(s_tdata[63:0]),
        .in_page_bytes(s_tdata[95:64]), .in_cell_bytes(s_tdata[111:96]),
        .in_zone(s_tdata[143:112]),
        .status(status), .cell_start(cell_start),
        .hit_cell_bytes(hit_cell_bytes), .cell_index(cell_index),
        .hit_zone(hit_zone), .found(found), .in_heap(in_heap),
        .at_boundary(at_boundary), .page_total(page_total),
        .mapped_bytes(mapped_bytes)
    );

    assign m_tdata = {5'd0, mapped_bytes, page_total, at_boundary, in_heap, found,
                      hit_zone, cell_index, hit_cell_bytes, cell_start, status};

    // no new item while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    // found implies a hit
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && found) |-> in_heap) else $error("found without hit");
    // one result per transfer
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid) else $error("repeated result");
endmodule
`default_nettype wire
